@@ hw/rtl/iprec_pkg.sv @@
// Shared types, constants and palette ROM for the ILDA point record encoder.
`timescale 1ns / 1ps
package iprec_pkg;

  typedef struct packed {
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] z_pos;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               blank_flag;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       record_end;
  } rec_byte_t;

  // Beat handed from one search cell to the next; idx has a spare bit so the
  // count can pass the last entry without wrapping
  typedef struct packed {
    logic        valid;
    logic [8:0]  idx;
    logic [17:0] best_sq;
    logic [7:0]  pick;
  } cell_beat_t;

  localparam logic [17:0] DIST_START   = 18'd195076;
  localparam logic [7:0]  STATUS_BLANK = 8'h40;
  localparam logic [7:0]  STATUS_LAST  = 8'h80;
  localparam logic [8:0]  LAST_ENTRY   = 9'd254;

  function automatic logic [23:0] palette(input logic [7:0] i);
    logic [23:0] p;
    case (i)
      8'd0: p = 24'h000000; 8'd1: p = 24'hFFFFFF; 8'd2: p = 24'hFF0000;
      8'd3: p = 24'hFFFF00; 8'd4: p = 24'h00FF00; 8'd5: p = 24'h00FFFF;
      8'd6: p = 24'h0000FF; 8'd7: p = 24'hFF00FF;
      8'd8: p = {8'd255,8'd128,8'd128}; 8'd9: p = {8'd255,8'd140,8'd128};
      8'd10: p = {8'd255,8'd151,8'd128}; 8'd11: p = {8'd255,8'd163,8'd128};
      8'd12: p = {8'd255,8'd174,8'd128}; 8'd13: p = {8'd255,8'd186,8'd128};
      8'd14: p = {8'd255,8'd197,8'd128}; 8'd15: p = {8'd255,8'd209,8'd128};
      8'd16: p = {8'd255,8'd220,8'd128}; 8'd17: p = {8'd255,8'd232,8'd128};
      8'd18: p = {8'd255,8'd243,8'd128}; 8'd19: p = {8'd255,8'd255,8'd128};
      8'd20: p = {8'd243,8'd255,8'd128}; 8'd21: p = {8'd232,8'd255,8'd128};
      8'd22: p = {8'd220,8'd255,8'd128}; 8'd23: p = {8'd209,8'd255,8'd128};
      8'd24: p = {8'd197,8'd255,8'd128}; 8'd25: p = {8'd186,8'd255,8'd128};
      8'd26: p = {8'd174,8'd255,8'd128}; 8'd27: p = {8'd163,8'd255,8'd128};
      8'd28: p = {8'd151,8'd255,8'd128}; 8'd29: p = {8'd140,8'd255,8'd128};
      8'd30: p = {8'd128,8'd255,8'd128}; 8'd31: p = {8'd128,8'd255,8'd140};
      8'd32: p = {8'd128,8'd255,8'd151}; 8'd33: p = {8'd128,8'd255,8'd163};
      8'd34: p = {8'd128,8'd255,8'd174}; 8'd35: p = {8'd128,8'd255,8'd186};
      8'd36: p = {8'd128,8'd255,8'd197}; 8'd37: p = {8'd128,8'd255,8'd209};
      8'd38: p = {8'd128,8'd255,8'd220}; 8'd39: p = {8'd128,8'd255,8'd232};
      8'd40: p = {8'd128,8'd255,8'd243}; 8'd41: p = {8'd128,8'd255,8'd255};
      8'd42: p = {8'd128,8'd243,8'd255}; 8'd43: p = {8'd128,8'd232,8'd255};
      8'd44: p = {8'd128,8'd220,8'd255}; 8'd45: p = {8'd128,8'd209,8'd255};
      8'd46: p = {8'd128,8'd197,8'd255}; 8'd47: p = {8'd128,8'd186,8'd255};
      8'd48: p = {8'd128,8'd174,8'd255}; 8'd49: p = {8'd128,8'd163,8'd255};
      8'd50: p = {8'd128,8'd151,8'd255}; 8'd51: p = {8'd128,8'd140,8'd255};
      8'd52: p = {8'd128,8'd128,8'd255}; 8'd53: p = {8'd140,8'd128,8'd255};
      8'd54: p = {8'd151,8'd128,8'd255}; 8'd55: p = {8'd163,8'd128,8'd255};
      8'd56: p = {8'd174,8'd128,8'd255}; 8'd57: p = {8'd186,8'd128,8'd255};
      8'd58: p = {8'd197,8'd128,8'd255}; 8'd59: p = {8'd209,8'd128,8'd255};
      8'd60: p = {8'd220,8'd128,8'd255}; 8'd61: p = {8'd232,8'd128,8'd255};
      8'd62: p = {8'd243,8'd128,8'd255}; 8'd63: p = {8'd255,8'd128,8'd255};
      8'd64: p = {8'd255,8'd128,8'd243}; 8'd65: p = {8'd255,8'd128,8'd232};
      8'd66: p = {8'd255,8'd128,8'd220}; 8'd67: p = {8'd255,8'd128,8'd209};
      8'd68: p = {8'd255,8'd128,8'd197}; 8'd69: p = {8'd255,8'd128,8'd186};
      8'd70: p = {8'd255,8'd128,8'd174}; 8'd71: p = {8'd255,8'd128,8'd163};
      8'd72: p = {8'd255,8'd128,8'd151}; 8'd73: p = {8'd255,8'd128,8'd140};
      8'd74: p = {8'd255,8'd0,8'd0};     8'd75: p = {8'd255,8'd23,8'd0};
      8'd76: p = {8'd255,8'd46,8'd0};    8'd77: p = {8'd255,8'd70,8'd0};
      8'd78: p = {8'd255,8'd93,8'd0};    8'd79: p = {8'd255,8'd116,8'd0};
      8'd80: p = {8'd255,8'd139,8'd0};   8'd81: p = {8'd255,8'd162,8'd0};
      8'd82: p = {8'd255,8'd185,8'd0};   8'd83: p = {8'd255,8'd209,8'd0};
      8'd84: p = {8'd255,8'd232,8'd0};   8'd85: p = {8'd255,8'd255,8'd0};
      8'd86: p = {8'd232,8'd255,8'd0};   8'd87: p = {8'd209,8'd255,8'd0};
      8'd88: p = {8'd185,8'd255,8'd0};   8'd89: p = {8'd162,8'd255,8'd0};
      8'd90: p = {8'd139,8'd255,8'd0};   8'd91: p = {8'd116,8'd255,8'd0};
      8'd92: p = {8'd93,8'd255,8'd0};    8'd93: p = {8'd70,8'd255,8'd0};
      8'd94: p = {8'd46,8'd255,8'd0};    8'd95: p = {8'd23,8'd255,8'd0};
      8'd96: p = {8'd0,8'd255,8'd0};     8'd97: p = {8'd0,8'd255,8'd23};
      8'd98: p = {8'd0,8'd255,8'd46};    8'd99: p = {8'd0,8'd255,8'd70};
      8'd100: p = {8'd0,8'd255,8'd93};   8'd101: p = {8'd0,8'd255,8'd116};
      8'd102: p = {8'd0,8'd255,8'd139};  8'd103: p = {8'd0,8'd255,8'd162};
      8'd104: p = {8'd0,8'd255,8'd185};  8'd105: p = {8'd0,8'd255,8'd209};
      8'd106: p = {8'd0,8'd255,8'd232};  8'd107: p = {8'd0,8'd255,8'd255};
      8'd108: p = {8'd0,8'd232,8'd255};  8'd109: p = {8'd0,8'd209,8'd255};
      8'd110: p = {8'd0,8'd185,8'd255};  8'd111: p = {8'd0,8'd162,8'd255};
      8'd112: p = {8'd0,8'd139,8'd255};  8'd113: p = {8'd0,8'd116,8'd255};
      8'd114: p = {8'd0,8'd93,8'd255};   8'd115: p = {8'd0,8'd70,8'd255};
      8'd116: p = {8'd0,8'd46,8'd255};   8'd117: p = {8'd0,8'd23,8'd255};
      8'd118: p = {8'd0,8'd0,8'd255};    8'd119: p = {8'd23,8'd0,8'd255};
      8'd120: p = {8'd46,8'd0,8'd255};   8'd121: p = {8'd70,8'd0,8'd255};
      8'd122: p = {8'd93,8'd0,8'd255};   8'd123: p = {8'd116,8'd0,8'd255};
      8'd124: p = {8'd139,8'd0,8'd255};  8'd125: p = {8'd162,8'd0,8'd255};
      8'd126: p = {8'd185,8'd0,8'd255};  8'd127: p = {8'd209,8'd0,8'd255};
      8'd128: p = {8'd232,8'd0,8'd255};  8'd129: p = {8'd255,8'd0,8'd255};
      8'd130: p = {8'd255,8'd0,8'd232};  8'd131: p = {8'd255,8'd0,8'd209};
      8'd132: p = {8'd255,8'd0,8'd185};  8'd133: p = {8'd255,8'd0,8'd162};
      8'd134: p = {8'd255,8'd0,8'd139};  8'd135: p = {8'd255,8'd0,8'd116};
      8'd136: p = {8'd255,8'd0,8'd93};   8'd137: p = {8'd255,8'd0,8'd70};
      8'd138: p = {8'd255,8'd0,8'd46};   8'd139: p = {8'd255,8'd0,8'd23};
      8'd140: p = {8'd128,8'd0,8'd0};    8'd141: p = {8'd128,8'd12,8'd0};
      8'd142: p = {8'd128,8'd23,8'd0};   8'd143: p = {8'd128,8'd35,8'd0};
      8'd144: p = {8'd128,8'd47,8'd0};   8'd145: p = {8'd128,8'd58,8'd0};
      8'd146: p = {8'd128,8'd70,8'd0};   8'd147: p = {8'd128,8'd81,8'd0};
      8'd148: p = {8'd128,8'd93,8'd0};   8'd149: p = {8'd128,8'd105,8'd0};
      8'd150: p = {8'd128,8'd116,8'd0};  8'd151: p = {8'd128,8'd128,8'd0};
      8'd152: p = {8'd116,8'd128,8'd0};  8'd153: p = {8'd105,8'd128,8'd0};
      8'd154: p = {8'd93,8'd128,8'd0};   8'd155: p = {8'd81,8'd128,8'd0};
      8'd156: p = {8'd70,8'd128,8'd0};   8'd157: p = {8'd58,8'd128,8'd0};
      8'd158: p = {8'd47,8'd128,8'd0};   8'd159: p = {8'd35,8'd128,8'd0};
      8'd160: p = {8'd23,8'd128,8'd0};   8'd161: p = {8'd12,8'd128,8'd0};
      8'd162: p = {8'd0,8'd128,8'd0};    8'd163: p = {8'd0,8'd128,8'd12};
      8'd164: p = {8'd0,8'd128,8'd23};   8'd165: p = {8'd0,8'd128,8'd35};
      8'd166: p = {8'd0,8'd128,8'd47};   8'd167: p = {8'd0,8'd128,8'd58};
      8'd168: p = {8'd0,8'd128,8'd70};   8'd169: p = {8'd0,8'd128,8'd81};
      8'd170: p = {8'd0,8'd128,8'd93};   8'd171: p = {8'd0,8'd128,8'd105};
      8'd172: p = {8'd0,8'd128,8'd116};  8'd173: p = {8'd0,8'd128,8'd128};
      8'd174: p = {8'd0,8'd116,8'd128};  8'd175: p = {8'd0,8'd105,8'd128};
      8'd176: p = {8'd0,8'd93,8'd128};   8'd177: p = {8'd0,8'd81,8'd128};
      8'd178: p = {8'd0,8'd70,8'd128};   8'd179: p = {8'd0,8'd58,8'd128};
      8'd180: p = {8'd0,8'd47,8'd128};   8'd181: p = {8'd0,8'd35,8'd128};
      8'd182: p = {8'd0,8'd23,8'd128};   8'd183: p = {8'd0,8'd12,8'd128};
      8'd184: p = {8'd0,8'd0,8'd128};    8'd185: p = {8'd12,8'd0,8'd128};
      8'd186: p = {8'd23,8'd0,8'd128};   8'd187: p = {8'd35,8'd0,8'd128};
      8'd188: p = {8'd47,8'd0,8'd128};   8'd189: p = {8'd58,8'd0,8'd128};
      8'd190: p = {8'd70,8'd0,8'd128};   8'd191: p = {8'd81,8'd0,8'd128};
      8'd192: p = {8'd93,8'd0,8'd128};   8'd193: p = {8'd105,8'd0,8'd128};
      8'd194: p = {8'd116,8'd0,8'd128};  8'd195: p = {8'd128,8'd0,8'd128};
      8'd196: p = {8'd128,8'd0,8'd116};  8'd197: p = {8'd128,8'd0,8'd105};
      8'd198: p = {8'd128,8'd0,8'd93};   8'd199: p = {8'd128,8'd0,8'd81};
      8'd200: p = {8'd128,8'd0,8'd70};   8'd201: p = {8'd128,8'd0,8'd58};
      8'd202: p = {8'd128,8'd0,8'd47};   8'd203: p = {8'd128,8'd0,8'd35};
      8'd204: p = {8'd128,8'd0,8'd23};   8'd205: p = {8'd128,8'd0,8'd12};
      8'd206: p = {8'd255,8'd192,8'd192}; 8'd207: p = {8'd255,8'd64,8'd64};
      8'd208: p = {8'd192,8'd0,8'd0};    8'd209: p = {8'd64,8'd0,8'd0};
      8'd210: p = {8'd255,8'd255,8'd192}; 8'd211: p = {8'd255,8'd255,8'd64};
      8'd212: p = {8'd192,8'd192,8'd0};  8'd213: p = {8'd64,8'd64,8'd0};
      8'd214: p = {8'd192,8'd255,8'd192}; 8'd215: p = {8'd64,8'd255,8'd64};
      8'd216: p = {8'd0,8'd192,8'd0};    8'd217: p = {8'd0,8'd64,8'd0};
      8'd218: p = {8'd192,8'd255,8'd255}; 8'd219: p = {8'd64,8'd255,8'd255};
      8'd220: p = {8'd0,8'd192,8'd192};  8'd221: p = {8'd0,8'd64,8'd64};
      8'd222: p = {8'd192,8'd192,8'd255}; 8'd223: p = {8'd64,8'd64,8'd255};
      8'd224: p = {8'd0,8'd0,8'd192};    8'd225: p = {8'd0,8'd0,8'd64};
      8'd226: p = {8'd255,8'd192,8'd255}; 8'd227: p = {8'd255,8'd64,8'd255};
      8'd228: p = {8'd192,8'd0,8'd192};  8'd229: p = {8'd64,8'd0,8'd64};
      8'd230: p = {8'd255,8'd96,8'd96};
      8'd231: p = {8'd255,8'd255,8'd255}; 8'd232: p = {8'd245,8'd245,8'd245};
      8'd233: p = {8'd235,8'd235,8'd235}; 8'd234: p = {8'd224,8'd224,8'd224};
      8'd235: p = {8'd213,8'd213,8'd213}; 8'd236: p = {8'd203,8'd203,8'd203};
      8'd237: p = {8'd192,8'd192,8'd192}; 8'd238: p = {8'd181,8'd181,8'd181};
      8'd239: p = {8'd171,8'd171,8'd171}; 8'd240: p = {8'd160,8'd160,8'd160};
      8'd241: p = {8'd149,8'd149,8'd149}; 8'd242: p = {8'd139,8'd139,8'd139};
      8'd243: p = {8'd128,8'd128,8'd128}; 8'd244: p = {8'd117,8'd117,8'd117};
      8'd245: p = {8'd107,8'd107,8'd107}; 8'd246: p = {8'd96,8'd96,8'd96};
      8'd247: p = {8'd85,8'd85,8'd85};   8'd248: p = {8'd75,8'd75,8'd75};
      8'd249: p = {8'd64,8'd64,8'd64};   8'd250: p = {8'd53,8'd53,8'd53};
      8'd251: p = {8'd43,8'd43,8'd43};   8'd252: p = {8'd32,8'd32,8'd32};
      8'd253: p = {8'd21,8'd21,8'd21};   8'd254: p = {8'd11,8'd11,8'd11};
      default: p = 24'h000000;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/iprec_cell.sv @@
// One search cell: compares one palette entry per beat and keeps the running best.
`timescale 1ns / 1ps
module iprec_cell
  import iprec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  cell_beat_t prev,
  output cell_beat_t next
);

  logic [23:0] entry;
  logic [7:0]  dr, dg, db;
  logic [17:0] cur_sq;
  logic [15:0] sr, sg, sb;

  // Squared distance to the entry this beat carries
  always_comb begin
    entry = palette(prev.idx[7:0]);
    dr = (red >= entry[23:16]) ? red - entry[23:16] : entry[23:16] - red;
    dg = (green >= entry[15:8]) ? green - entry[15:8] : entry[15:8] - green;
    db = (blue >= entry[7:0]) ? blue - entry[7:0] : entry[7:0] - blue;
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    cur_sq = 18'(sr) + 18'(sg) + 18'(sb);
  end

  // Strict less-than keeps the first entry on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else begin
      next.valid <= prev.valid;
    end
    next.idx <= prev.idx + 9'd1;
    if (cur_sq < prev.best_sq) begin
      next.best_sq <= cur_sq;
      next.pick <= prev.idx[7:0];
    end else begin
      next.best_sq <= prev.best_sq;
      next.pick <= prev.pick;
    end
  end

endmodule

@@ hw/rtl/ilda_point_record_encoder_unit.sv @@
// Top level: color cache, looped cell chain palette search and record byte serializer.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall | point_t
//  out     | output    | out_valid/out_stall | rec_byte_t
//  cfg     | input     | cfg_we            | cfg_data (three_d_mode)
//
// A point with a cached color is accepted and then sends its 6 or 8 byte beats. A miss
// adds a palette sweep: one beat circles the cell ring, one entry per cycle, until it
// has passed entry 254. Reset is synchronous and clears cache and mode. Output stalls
// delay the record; a stalled output holds its byte; the input is taken only when the
// unit is idle.
`timescale 1ns / 1ps
module ilda_point_record_encoder_unit
  import iprec_pkg::*;
#(
  parameter int NCELLS = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  point_t    in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rec_byte_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state;
  logic       three_d_mode;
  point_t     pt;
  logic [7:0] cached_red, cached_green, cached_blue, cached_index;
  logic [2:0] byte_no;
  logic [7:0] idx_out;

  cell_beat_t chain [NCELLS+1];
  cell_beat_t head;
  logic       hit;
  logic       accept;
  logic       sweep_done;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign hit = (in_data.red == cached_red) && (in_data.green == cached_green) &&
               (in_data.blue == cached_blue);

  // Ring head: start beat on entry, loop the tail back while the sweep runs
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (accept && !hit) begin
      head.valid   <= 1'b1;
      head.idx     <= 9'd0;
      head.best_sq <= DIST_START;
      head.pick    <= 8'd0;
    end else begin
      head.valid <= 1'b0;
    end
  end

  // Feed from the head on the first lap, from the tail afterward
  always_comb begin
    if (head.valid) begin
      chain[0] = head;
    end else begin
      chain[0] = chain[NCELLS];
      chain[0].valid = chain[NCELLS].valid && (state == ST_SRCH) &&
                       (chain[NCELLS].idx <= LAST_ENTRY);
    end
  end

  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    cell_beat_t gated;
    always_comb begin
      gated = chain[c];
      // Entries past the searched range never win
      if (chain[c].idx > LAST_ENTRY) begin
        gated.best_sq = 18'd0;
      end
    end
    iprec_cell u_cell (
      .clk(clk), .rst(rst),
      .red(pt.red), .green(pt.green), .blue(pt.blue),
      .prev(chain[c].idx > LAST_ENTRY ? gated : chain[c]),
      .next(chain[c+1])
    );
  end

  assign sweep_done = chain[NCELLS].valid && (state == ST_SRCH) &&
                      (chain[NCELLS].idx > LAST_ENTRY);

  // Control, cache and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      three_d_mode <= 1'b0;
      cached_red <= 8'd0;
      cached_green <= 8'd0;
      cached_blue <= 8'd0;
      cached_index <= 8'd0;
      byte_no <= 3'd0;
    end else begin
      if (cfg_we) three_d_mode <= cfg_data;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pt <= in_data;
            byte_no <= 3'd0;
            if (hit) begin
              idx_out <= cached_index;
              state <= ST_SEND;
            end else begin
              state <= ST_SRCH;
            end
          end
        end
        ST_SRCH: begin
          if (sweep_done) begin
            idx_out <= chain[NCELLS].pick;
            cached_red <= pt.red;
            cached_green <= pt.green;
            cached_blue <= pt.blue;
            cached_index <= chain[NCELLS].pick;
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!out_stall) begin
            if (out_data.record_end) begin
              state <= ST_IDLE;
            end
            byte_no <= byte_no + 3'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Record byte select; 2D records skip the z bytes
  logic [7:0] status;
  logic [2:0] slot;
  always_comb begin
    status = 8'd0;
    if (pt.blank_flag || ((pt.red | pt.green | pt.blue) == 8'd0)) status |= STATUS_BLANK;
    if (pt.last_point) status |= STATUS_LAST;
    slot = (!three_d_mode && byte_no >= 3'd4) ? byte_no + 3'd2 : byte_no;
    case (slot)
      3'd0: out_data.out_byte = pt.x_pos[15:8];
      3'd1: out_data.out_byte = pt.x_pos[7:0];
      3'd2: out_data.out_byte = pt.y_pos[15:8];
      3'd3: out_data.out_byte = pt.y_pos[7:0];
      3'd4: out_data.out_byte = pt.z_pos[15:8];
      3'd5: out_data.out_byte = pt.z_pos[7:0];
      3'd6: out_data.out_byte = status;
      default: out_data.out_byte = idx_out;
    endcase
    out_data.record_end = (slot == 3'd7);
  end

  assign out_valid = (state == ST_SEND);

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_cache_hit_send: assert property (@(posedge clk) disable iff (rst)
    (accept && hit) |=> (state == ST_SEND)) else $error("cache hit did not skip search");
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.record_end) |=> (state == ST_IDLE))
    else $error("record end did not release unit");

endmodule

@@ dv/tb_top.sv @@
// Testbench for the ILDA point record encoder: random points checked byte by byte.
`timescale 1ns / 1ps

// Expected record bytes and the check against them
class record_board;
  iprec_pkg::rec_byte_t pending_bytes[$];
  int errors;
  logic mode_3d;
  logic [7:0] hit_r, hit_g, hit_b, hit_idx;

  function new();
    errors = 0;
    mode_3d = 0;
    hit_r = 0; hit_g = 0; hit_b = 0; hit_idx = 0;
  endfunction

  // Nearest palette entry over 0..254; lowest index wins a tie
  function logic [7:0] nearest_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [23:0] c;
    int best, d, dr, dg, db;
    logic [7:0] pick;
    best = 195076;
    pick = 0;
    for (int i = 0; i < 255; i++) begin
      c = palette_rgb(i);
      dr = int'(r) - int'(c[23:16]);
      dg = int'(g) - int'(c[15:8]);
      db = int'(b) - int'(c[7:0]);
      d = dr * dr + dg * dg + db * db;
      if (d < best) begin
        best = d;
        pick = i[7:0];
      end
    end
    return pick;
  endfunction

  function void push_byte(logic [7:0] v, logic e);
    iprec_pkg::rec_byte_t rb;
    rb.out_byte = v;
    rb.record_end = e;
    pending_bytes.push_back(rb);
  endfunction

  // Note an accepted point and queue its record bytes
  function void note_point(iprec_pkg::point_t p);
    logic [7:0] idx, status;
    if (p.red == hit_r && p.green == hit_g && p.blue == hit_b) idx = hit_idx;
    else begin
      idx = nearest_color(p.red, p.green, p.blue);
      hit_r = p.red; hit_g = p.green; hit_b = p.blue; hit_idx = idx;
    end
    status = 8'h00;
    if ((p.red | p.green | p.blue) == 0 || p.blank_flag) status |= iprec_pkg::STATUS_BLANK;
    if (p.last_point) status |= iprec_pkg::STATUS_LAST;
    push_byte(p.x_pos[15:8], 1'b0);
    push_byte(p.x_pos[7:0], 1'b0);
    push_byte(p.y_pos[15:8], 1'b0);
    push_byte(p.y_pos[7:0], 1'b0);
    if (mode_3d) begin
      push_byte(p.z_pos[15:8], 1'b0);
      push_byte(p.z_pos[7:0], 1'b0);
    end
    push_byte(status, 1'b0);
    push_byte(idx, 1'b1);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_byte(iprec_pkg::rec_byte_t got);
    iprec_pkg::rec_byte_t want;
    if (pending_bytes.size() == 0) begin
      report($sformatf("unexpected beat %h/%b", got.out_byte, got.record_end));
      return;
    end
    want = pending_bytes.pop_front();
    if (got.out_byte !== want.out_byte)
      report($sformatf("out_byte got %h want %h", got.out_byte, want.out_byte));
    if (got.record_end !== want.record_end)
      report($sformatf("record_end got %b want %b", got.record_end, want.record_end));
  endtask

  // Own copy of the standard palette, built from its regular runs
  static function logic [23:0] palette_rgb(int i);
    logic [23:0] fixed_tbl[0:24];
    int ramp_a[11], ramp_b[11], g;
    fixed_tbl = '{24'hFFC0C0, 24'hFF4040, 24'hC00000, 24'h400000, 24'hFFFFC0, 24'hFFFF40,
                  24'hC0C000, 24'h404000, 24'hC0FFC0, 24'h40FF40, 24'h00C000, 24'h004000,
                  24'hC0FFFF, 24'h40FFFF, 24'h00C0C0, 24'h004040, 24'hC0C0FF, 24'h4040FF,
                  24'h0000C0, 24'h000040, 24'hFFC0FF, 24'hFF40FF, 24'hC000C0, 24'h400040,
                  24'hFF6060};
    ramp_a = '{128, 140, 151, 163, 174, 186, 197, 209, 220, 232, 243};
    ramp_b = '{0, 23, 46, 70, 93, 116, 139, 162, 185, 209, 232};
    if (i < 8) begin
      case (i)
        0: return 24'h000000; 1: return 24'hFFFFFF; 2: return 24'hFF0000;
        3: return 24'hFFFF00; 4: return 24'h00FF00; 5: return 24'h00FFFF;
        6: return 24'h0000FF; default: return 24'hFF00FF;
      endcase
    end
    // Pastel hue wheel, 6 runs of 11 from (255,128,128)
    if (i < 74) return wheel((i - 8) / 11, (i - 8) % 11, 8'd255, 8'd128, ramp_a, 0);
    // Saturated hue wheel
    if (i < 140) return wheel((i - 74) / 11, (i - 74) % 11, 8'd255, 8'd0, ramp_b, 0);
    // Dark hue wheel
    if (i < 206) return wheel((i - 140) / 11, (i - 140) % 11, 8'd128, 8'd0, ramp_b, 1);
    if (i < 231) return fixed_tbl[i - 206];
    case (i - 231)
      0: g = 255;  1: g = 245;  2: g = 235;  3: g = 224;  4: g = 213;  5: g = 203;
      6: g = 192;  7: g = 181;  8: g = 171;  9: g = 160;  10: g = 149; 11: g = 139;
      12: g = 128; 13: g = 117; 14: g = 107; 15: g = 96;  16: g = 85;  17: g = 75;
      18: g = 64;  19: g = 53;  20: g = 43;  21: g = 32;  22: g = 21;  23: g = 11;
      default: g = 0;
    endcase
    return {g[7:0], g[7:0], g[7:0]};
  endfunction

  // One run of a hue wheel: a rising or a falling ramp between lo and hi
  static function logic [23:0] wheel(int run, int k, logic [7:0] hi, logic [7:0] lo,
                                     int ramp[11], bit dark);
    logic [7:0] up, dn;
    int v;
    v = ramp[k];
    if (dark) begin
      case (k)
        0: v = 0; 1: v = 12; 2: v = 23; 3: v = 35; 4: v = 47; 5: v = 58;
        6: v = 70; 7: v = 81; 8: v = 93; 9: v = 105; default: v = 116;
      endcase
    end
    up = v[7:0];
    dn = (k == 0) ? hi : ramp_down(k, hi, lo, ramp, dark);
    case (run)
      0: return {hi, up, lo};
      1: return {dn, hi, lo};
      2: return {lo, hi, up};
      3: return {lo, dn, hi};
      4: return {up, lo, hi};
      default: return {hi, lo, dn};
    endcase
  endfunction

  static function logic [7:0] ramp_down(int k, logic [7:0] hi, logic [7:0] lo,
                                        int ramp[11], bit dark);
    int w;
    if (dark) begin
      case (k)
        1: w = 116; 2: w = 105; 3: w = 93; 4: w = 81; 5: w = 70;
        6: w = 58; 7: w = 47; 8: w = 35; 9: w = 23; default: w = 12;
      endcase
    end else if (lo == 8'd0) begin
      case (k)
        1: w = 232; 2: w = 209; 3: w = 185; 4: w = 162; 5: w = 139;
        6: w = 116; 7: w = 93; 8: w = 70; 9: w = 46; default: w = 23;
      endcase
    end else begin
      case (k)
        1: w = 243; 2: w = 232; 3: w = 220; 4: w = 209; 5: w = 197;
        6: w = 186; 7: w = 174; 8: w = 163; 9: w = 151; default: w = 140;
      endcase
    end
    return w[7:0];
  endfunction
endclass

module tb_top;
  import iprec_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  point_t in_data = '0;
  logic out_valid;
  logic out_stall = 1;
  rec_byte_t out_data;
  logic cfg_we = 0;
  logic cfg_data = 0;

  record_board board = new();
  bit driving_done = 0;

  ilda_point_record_encoder_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Mostly short gaps, now and then a long one
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one point and hold it until the unit takes it; the extra edge keeps
  // the drop of valid and the next raise in separate time steps
  task send_point(point_t p);
    repeat (gap_len() + 1) @(posedge clk);
    in_valid <= 1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_point(p);
    in_valid <= 0;
  endtask

  task write_mode(logic m);
    cfg_we <= 1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 0;
    board.mode_3d = m;
  endtask

  // Drain all expected bytes, then let the unit settle before a mode change
  task wait_idle();
    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function point_t mk_point(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic bl, logic lp);
    point_t p;
    p.x_pos = x; p.y_pos = y; p.z_pos = z;
    p.red = r; p.green = g; p.blue = b;
    p.blank_flag = bl; p.last_point = lp;
    return p;
  endfunction

  function point_t rand_point();
    point_t p;
    logic [95:0] raw;
    int sel;
    raw = {$urandom, $urandom, $urandom};
    p = raw[$bits(point_t)-1:0];
    sel = $urandom_range(0, 9);
    // Pull colors toward black, repeats and extremes
    if (sel == 0) {p.red, p.green, p.blue} = 24'd0;
    else if (sel == 1) {p.red, p.green, p.blue} = {board.hit_r, board.hit_g, board.hit_b};
    else if (sel == 2) {p.red, p.green, p.blue} = {3{8'hFF}};
    return p;
  endfunction

  // Output side: stall runs of random length, check every accepted beat
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_byte(out_data);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left <= gap_len();
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: coordinate extremes, black, blank, last, z ignored in 2D
    send_point(mk_point(16'h8000, 16'h7FFF, 16'hFFFF, 0, 0, 0, 0, 0));
    send_point(mk_point(16'h7FFF, 16'h8000, 16'h1234, 255, 255, 255, 1, 1));
    send_point(mk_point(16'hFFFF, 16'h0000, 16'h8000, 255, 0, 0, 0, 1));
    send_point(mk_point(16'h0001, 16'hFFFF, 16'h7FFF, 255, 0, 0, 1, 0));
    send_point(mk_point(16'h00FF, 16'hFF00, 16'h0000, 11, 11, 11, 0, 0));
    send_point(mk_point(16'h5555, 16'hAAAA, 16'h0F0F, 1, 0, 0, 0, 0));
    send_point(mk_point(16'hAAAA, 16'h5555, 16'hF0F0, 0, 0, 255, 0, 1));
    wait_idle();
    write_mode(1);
    send_point(mk_point(16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0, 1, 1));
    send_point(mk_point(16'h7FFF, 16'h8000, 16'h7FFF, 128, 128, 128, 0, 0));
    send_point(mk_point(16'h1234, 16'h5678, 16'hFFFF, 128, 128, 128, 0, 1));
    send_point(mk_point(16'h0000, 16'h0000, 16'h0000, 6, 200, 97, 0, 0));
    send_point(mk_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1, 0, 0));

    // Random phases alternating modes, then a short random run in 3D mode
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 40; n++) send_point(rand_point());
      wait_idle();
      write_mode(ph[0]);
    end
    for (int n = 0; n < 10; n++) send_point(rand_point());
    driving_done = 1;
  end

  initial begin
    wait (driving_done);
    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/iprec_pkg.sv
hw/rtl/iprec_cell.sv
hw/rtl/ilda_point_record_encoder_unit.sv
dv/tb_top.sv
